/* hw/rtl/ackcw_pkg.sv */
// shared types, codes and constants of the ack congestion window controller
// no dependencies; used by the interfaces, the sequencer, the divider and the top level
package ackcw_pkg;

	// fixed field widths
	localparam int SEQ_FIELD_W = 24;
	localparam int WIN_INT_W   = 16;
	localparam int DUP_W       = 24;

	// default parameter values
	localparam int FRAC_BITS_DEF = 8;
	localparam int SEQ_BITS_DEF  = 24;

	// configuration port
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_MIN_WINDOW = 2'd0,
		REG_SSTHRESH   = 2'd1,
		REG_TOTAL      = 2'd2
	} cfg_reg_t;

	localparam logic [WIN_INT_W-1:0]   MIN_WINDOW_RST = 16'd32;
	localparam logic [WIN_INT_W-1:0]   SSTHRESH_RST   = 16'd128;
	localparam logic [SEQ_FIELD_W-1:0] TOTAL_RST      = 24'd0;

	// duplicate count that enters fast recovery
	localparam logic [DUP_W-1:0] DUP_ENTER = 24'd3;

	// program counter width of the sequencer
	localparam int PC_W = 5;

	// datapath operations of one control word
	typedef enum logic [3:0] {
		OP_NOP       = 4'd0,
		OP_WAIT      = 4'd1,
		OP_DELTA     = 4'd2,
		OP_DIV_START = 4'd3,
		OP_DIV_STEP  = 4'd4,
		OP_W_QUO     = 4'd5,
		OP_W_GROWN   = 4'd6,
		OP_NEW_ACK   = 4'd7,
		OP_TAIL_W    = 4'd8,
		OP_DUP_INC   = 4'd9,
		OP_FR_EXIT   = 4'd10,
		OP_FR_DUP    = 4'd11,
		OP_FR_ENTER  = 4'd12,
		OP_TIMEOUT   = 4'd13,
		OP_FINISH    = 4'd14,
		OP_EMIT      = 4'd15
	} op_t;

	// jump conditions of one control word
	typedef enum logic [3:0] {
		C_ALWAYS      = 4'd0,
		C_NO_ACCEPT   = 4'd1,
		C_FIN         = 4'd2,
		C_REQ         = 4'd3,
		C_ACK_TOTAL   = 4'd4,
		C_NOT_SS      = 4'd5,
		C_NOT_FR      = 4'd6,
		C_ACK_EQ_LAST = 4'd7,
		C_ACK_LT_LAST = 4'd8,
		C_GROWN_LE_TH = 4'd9,
		C_DIV_MORE    = 4'd10,
		C_DUP_NE_3    = 4'd11,
		C_OUT_FREE    = 4'd12
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// status flags from the datapath to the sequencer
	typedef struct packed {
		logic no_accept;
		logic fin;
		logic req;
		logic ack_total;
		logic not_ss;
		logic not_fr;
		logic ack_eq_last;
		logic ack_lt_last;
		logic grown_le_th;
		logic div_more;
		logic dup_ne_3;
		logic out_free;
	} flags_t;

	// channel payloads
	typedef struct packed {
		logic                   req_type;
		logic [SEQ_FIELD_W-1:0] ack_number;
	} evt_word_t;

	typedef struct packed {
		logic [SEQ_FIELD_W-1:0] window_base;
		logic [SEQ_FIELD_W-1:0] window_tail;
		logic [WIN_INT_W-1:0]   congestion_window;
		logic                   retransmit_valid;
		logic [SEQ_FIELD_W-1:0] retransmit_seq;
		logic                   transfer_done;
	} upd_word_t;

endpackage

/* hw/rtl/ackcw_evt_if.sv */
// valid/ready channel carrying one ack or timeout word
// depends on ackcw_pkg
interface ackcw_evt_if;
	import ackcw_pkg::*;

	logic      valid;
	logic      ready;
	evt_word_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

/* hw/rtl/ackcw_upd_if.sv */
// valid/ready channel carrying one window update word
// depends on ackcw_pkg
interface ackcw_upd_if;
	import ackcw_pkg::*;

	logic      valid;
	logic      ready;
	upd_word_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

/* hw/rtl/ack_congestion_window_control_top.sv */
// top level of the ack congestion window controller: config registers, datapath, result register
// depends on ackcw_pkg, ackcw_evt_if, ackcw_upd_if, ackcw_seq, ackcw_div
//
//  channel   dir   handshake            word
//  ack_evt   in    valid/ready          req_type, ack_number
//  win_upd   out   valid/ready          window_base .. transfer_done
//  apb       in    psel/penable/pready  min_window, slow_start_threshold, total_packets
//
// a word runs through the microcode steps from its accept to the output register; a slow-start
// ack that crosses the threshold also runs the divider loop, which dominates the time, two
// quotient bits per cycle; the next word is taken once the program is back at its wait step
// reset leaves slow start on with a zero window; no clearing pass
// a new ack word is taken only while the program waits; a finished word sits in the output
// register, and the program stalls at its emit step while that register is still full
module ack_congestion_window_control_top #(
	parameter int FRAC_BITS = ackcw_pkg::FRAC_BITS_DEF,
	parameter int SEQ_BITS  = ackcw_pkg::SEQ_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ackcw_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [ackcw_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [ackcw_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                 pready,
	ackcw_evt_if.sink                            ack_evt,
	ackcw_upd_if.source                          win_upd
);
	import ackcw_pkg::*;

	localparam int WinW = WIN_INT_W + FRAC_BITS;
	localparam int QW   = SEQ_FIELD_W + FRAC_BITS;
	localparam int GrW  = SEQ_FIELD_W + FRAC_BITS + 2;
	localparam logic [WinW-1:0] WinMax = {WinW{1'b1}};
	localparam logic [SEQ_FIELD_W-1:0] AckMask = (SEQ_BITS >= SEQ_FIELD_W) ?
		{SEQ_FIELD_W{1'b1}} : SEQ_FIELD_W'((64'd1 << SEQ_BITS) - 64'd1);

	// configuration registers
	logic [WIN_INT_W-1:0]   min_win_q;
	logic [WIN_INT_W-1:0]   ssthresh_q;
	logic [SEQ_FIELD_W-1:0] total_q;
	cfg_reg_t               reg_idx;

	// controller state
	logic [WinW-1:0]        win_q;
	logic [SEQ_FIELD_W-1:0] last_q;
	logic [DUP_W-1:0]       dup_q;
	logic                   ss_q;
	logic                   fr_q;
	logic [SEQ_BITS-1:0]    base_q;
	logic [SEQ_BITS-1:0]    tail_q;
	logic                   fin_q;

	// working registers of one word
	logic                   req_q;
	logic [SEQ_FIELD_W-1:0] ack_q;
	logic [SEQ_FIELD_W-1:0] delta_q;
	logic [GrW-1:0]         grown_q;
	logic                   rt_q;

	// result register
	logic                   upd_valid_q;
	upd_word_t              upd_q;

	ctrl_t                  cw;
	flags_t                 flags;
	logic                   accept;
	logic                   out_free;
	logic [WIN_INT_W-1:0]   win_int;
	logic [QW-1:0]          quo;
	logic                   div_more;
	logic [SEQ_FIELD_W-1:0] delta_now;
	logic [GrW-1:0]         grown_now;
	logic [QW:0]            sum_quo;
	logic [WinW:0]          sum_one;
	logic [WinW-1:0]        min_fixed;
	logic [WinW-1:0]        ss_fixed;

	// apb register file
	assign pready  = 1'b1;
	assign reg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_win_q  <= MIN_WINDOW_RST;
			ssthresh_q <= SSTHRESH_RST;
			total_q    <= TOTAL_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_MIN_WINDOW: min_win_q  <= pwdata[WIN_INT_W-1:0];
				REG_SSTHRESH:   ssthresh_q <= pwdata[WIN_INT_W-1:0];
				REG_TOTAL:      total_q    <= pwdata[SEQ_FIELD_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MIN_WINDOW: prdata = CFG_DATA_W'(min_win_q);
			REG_SSTHRESH:   prdata = CFG_DATA_W'(ssthresh_q);
			REG_TOTAL:      prdata = CFG_DATA_W'(total_q);
			default:        prdata = '0;
		endcase
	end

	// sequencer and divider
	ackcw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw)
	);

	ackcw_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cw.op == OP_DIV_START),
		.step    (cw.op == OP_DIV_STEP),
		.delta   (delta_q),
		.win_int (win_int),
		.quo     (quo),
		.more    (div_more)
	);

	// handshakes
	assign ack_evt.ready = (cw.op == OP_WAIT);
	assign accept        = ack_evt.valid && ack_evt.ready;
	assign out_free      = !upd_valid_q || win_upd.ready;
	assign win_upd.valid = upd_valid_q;
	assign win_upd.item  = upd_q;

	// datapath arithmetic
	assign win_int   = win_q[WinW-1:FRAC_BITS];
	assign delta_now = ack_q - last_q;
	assign grown_now = GrW'(win_q) + (GrW'(delta_now) << (FRAC_BITS + 1));
	assign sum_quo   = (QW + 1)'(win_q) + (QW + 1)'(quo);
	assign sum_one   = {1'b0, win_q} + ((WinW + 1)'(1) << FRAC_BITS);
	assign min_fixed = {min_win_q, {FRAC_BITS{1'b0}}};
	assign ss_fixed  = {ssthresh_q, {FRAC_BITS{1'b0}}};

	// status flags for the jump conditions
	always_comb begin
		flags.no_accept   = !accept;
		flags.fin         = fin_q;
		flags.req         = req_q;
		flags.ack_total   = (ack_q == total_q);
		flags.not_ss      = !ss_q;
		flags.not_fr      = !fr_q;
		flags.ack_eq_last = (ack_q == last_q);
		flags.ack_lt_last = (ack_q < last_q);
		flags.grown_le_th = (grown_q <= (GrW'(ssthresh_q) << FRAC_BITS));
		flags.div_more    = div_more;
		flags.dup_ne_3    = (dup_q != DUP_ENTER);
		flags.out_free    = out_free;
	end

	// controller state updates, one operation per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			last_q <= '0;
			dup_q  <= '0;
			ss_q   <= 1'b1;
			fr_q   <= 1'b0;
			base_q <= '0;
			tail_q <= '0;
			fin_q  <= 1'b0;
			rt_q   <= 1'b0;
		end else begin
			unique case (cw.op)
				OP_WAIT: begin
					if (accept) begin
						rt_q <= 1'b0;
					end
				end
				OP_W_QUO: begin
					win_q <= (sum_quo > (QW + 1)'(WinMax)) ? WinMax : WinW'(sum_quo);
				end
				OP_W_GROWN: begin
					win_q <= (grown_q > GrW'(WinMax)) ? WinMax : WinW'(grown_q);
				end
				OP_NEW_ACK: begin
					dup_q  <= '0;
					base_q <= base_q + SEQ_BITS'(delta_q);
					last_q <= ack_q;
				end
				OP_TAIL_W: begin
					tail_q <= base_q + SEQ_BITS'(win_int) - SEQ_BITS'(1);
				end
				OP_DUP_INC: begin
					if (dup_q != {DUP_W{1'b1}}) begin
						dup_q <= dup_q + DUP_W'(1);
					end
				end
				OP_FR_EXIT: begin
					win_q <= ss_fixed;
					ss_q  <= 1'b1;
					fr_q  <= 1'b0;
				end
				OP_FR_DUP: begin
					win_q  <= (sum_one > (WinW + 1)'(WinMax)) ? WinMax : WinW'(sum_one);
					tail_q <= tail_q + SEQ_BITS'(1);
					rt_q   <= 1'b1;
					if (dup_q != {DUP_W{1'b1}}) begin
						dup_q <= dup_q + DUP_W'(1);
					end
				end
				OP_FR_ENTER: begin
					win_q <= min_fixed;
					fr_q  <= 1'b1;
					ss_q  <= 1'b0;
					rt_q  <= 1'b1;
				end
				OP_TIMEOUT: begin
					win_q  <= min_fixed;
					dup_q  <= '0;
					ss_q   <= 1'b1;
					fr_q   <= 1'b0;
					tail_q <= base_q;
				end
				OP_FINISH: begin
					fin_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// working registers of the current word
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= ack_evt.item.req_type;
			ack_q <= ack_evt.item.ack_number & AckMask;
		end
		if (cw.op == OP_DELTA || cw.op == OP_FR_EXIT) begin
			delta_q <= delta_now;
		end
		if (cw.op == OP_DELTA) begin
			grown_q <= grown_now;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_valid_q <= 1'b0;
		end else if (cw.op == OP_EMIT && out_free) begin
			upd_valid_q <= 1'b1;
		end else if (win_upd.ready) begin
			upd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_EMIT && out_free) begin
			upd_q.window_base       <= SEQ_FIELD_W'(base_q);
			upd_q.window_tail       <= SEQ_FIELD_W'(tail_q);
			upd_q.congestion_window <= win_int;
			upd_q.retransmit_valid  <= rt_q;
			upd_q.retransmit_seq    <= rt_q ? ((ack_q + SEQ_FIELD_W'(1)) & AckMask) : '0;
			upd_q.transfer_done     <= fin_q;
		end
	end

endmodule

/* hw/rtl/ackcw_seq.sv */
// microcode sequencer: program rom, step counter and conditional jumps
// depends on ackcw_pkg
module ackcw_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  ackcw_pkg::flags_t flags,
	output ackcw_pkg::ctrl_t  cw
);
	import ackcw_pkg::*;

	// program labels
	localparam logic [PC_W-1:0] S_WAIT    = 5'd0;
	localparam logic [PC_W-1:0] S_SSGROWN = 5'd12;
	localparam logic [PC_W-1:0] S_SSNEW   = 5'd13;
	localparam logic [PC_W-1:0] S_SSDUP   = 5'd15;
	localparam logic [PC_W-1:0] S_FRCHK   = 5'd16;
	localparam logic [PC_W-1:0] S_FRDUP   = 5'd22;
	localparam logic [PC_W-1:0] S_DUP3    = 5'd23;
	localparam logic [PC_W-1:0] S_TMO     = 5'd26;
	localparam logic [PC_W-1:0] S_DONE    = 5'd27;
	localparam logic [PC_W-1:0] S_EMIT    = 5'd28;

	logic [PC_W-1:0] pc_q;
	logic            take;

	// program: one word per step, jump to target when the condition holds
	function automatic ctrl_t rom(input logic [PC_W-1:0] a);
		ctrl_t w;
		begin
			w = '{op: OP_WAIT, cond: C_NO_ACCEPT, target: S_WAIT};
			case (a)
				5'd0:  w = '{op: OP_WAIT,      cond: C_NO_ACCEPT,   target: S_WAIT};
				5'd1:  w = '{op: OP_NOP,       cond: C_FIN,         target: S_EMIT};
				5'd2:  w = '{op: OP_NOP,       cond: C_REQ,         target: S_TMO};
				5'd3:  w = '{op: OP_NOP,       cond: C_ACK_TOTAL,   target: S_DONE};
				5'd4:  w = '{op: OP_NOP,       cond: C_NOT_SS,      target: S_FRCHK};
				5'd5:  w = '{op: OP_NOP,       cond: C_ACK_EQ_LAST, target: S_SSDUP};
				5'd6:  w = '{op: OP_NOP,       cond: C_ACK_LT_LAST, target: S_DUP3};
				5'd7:  w = '{op: OP_DELTA,     cond: C_ALWAYS,      target: 5'd8};
				5'd8:  w = '{op: OP_NOP,       cond: C_GROWN_LE_TH, target: S_SSGROWN};
				5'd9:  w = '{op: OP_DIV_START, cond: C_ALWAYS,      target: 5'd10};
				5'd10: w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,    target: 5'd10};
				5'd11: w = '{op: OP_W_QUO,     cond: C_ALWAYS,      target: S_SSNEW};
				5'd12: w = '{op: OP_W_GROWN,   cond: C_ALWAYS,      target: S_SSNEW};
				5'd13: w = '{op: OP_NEW_ACK,   cond: C_ALWAYS,      target: 5'd14};
				5'd14: w = '{op: OP_TAIL_W,    cond: C_ALWAYS,      target: S_DUP3};
				5'd15: w = '{op: OP_DUP_INC,   cond: C_ALWAYS,      target: S_DUP3};
				5'd16: w = '{op: OP_NOP,       cond: C_NOT_FR,      target: S_DUP3};
				5'd17: w = '{op: OP_NOP,       cond: C_ACK_LT_LAST, target: S_DUP3};
				5'd18: w = '{op: OP_NOP,       cond: C_ACK_EQ_LAST, target: S_FRDUP};
				5'd19: w = '{op: OP_FR_EXIT,   cond: C_ALWAYS,      target: 5'd20};
				5'd20: w = '{op: OP_NEW_ACK,   cond: C_ALWAYS,      target: 5'd21};
				5'd21: w = '{op: OP_TAIL_W,    cond: C_ALWAYS,      target: S_DUP3};
				5'd22: w = '{op: OP_FR_DUP,    cond: C_ALWAYS,      target: S_DUP3};
				5'd23: w = '{op: OP_NOP,       cond: C_DUP_NE_3,    target: S_EMIT};
				5'd24: w = '{op: OP_FR_ENTER,  cond: C_ALWAYS,      target: 5'd25};
				5'd25: w = '{op: OP_TAIL_W,    cond: C_ALWAYS,      target: S_EMIT};
				5'd26: w = '{op: OP_TIMEOUT,   cond: C_ALWAYS,      target: S_EMIT};
				5'd27: w = '{op: OP_FINISH,    cond: C_ALWAYS,      target: S_EMIT};
				5'd28: w = '{op: OP_EMIT,      cond: C_OUT_FREE,    target: S_WAIT};
				5'd29: w = '{op: OP_NOP,       cond: C_ALWAYS,      target: S_EMIT};
				default: w = '{op: OP_NOP,     cond: C_ALWAYS,      target: S_WAIT};
			endcase
			return w;
		end
	endfunction

	assign cw = rom(pc_q);

	// condition select
	always_comb begin
		unique case (cw.cond)
			C_ALWAYS:      take = 1'b1;
			C_NO_ACCEPT:   take = flags.no_accept;
			C_FIN:         take = flags.fin;
			C_REQ:         take = flags.req;
			C_ACK_TOTAL:   take = flags.ack_total;
			C_NOT_SS:      take = flags.not_ss;
			C_NOT_FR:      take = flags.not_fr;
			C_ACK_EQ_LAST: take = flags.ack_eq_last;
			C_ACK_LT_LAST: take = flags.ack_lt_last;
			C_GROWN_LE_TH: take = flags.grown_le_th;
			C_DIV_MORE:    take = flags.div_more;
			C_DUP_NE_3:    take = flags.dup_ne_3;
			C_OUT_FREE:    take = flags.out_free;
			default:       take = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
		end else if (take) begin
			pc_q <= cw.target;
		end else begin
			pc_q <= pc_q + 5'd1;
		end
	end

endmodule

/* hw/rtl/ackcw_div.sv */
// radix-4 restoring divider, two quotient bits per cycle while step is high
// depends on ackcw_pkg; computes (delta << FRAC_BITS) / max(1, window integer part)
module ackcw_div #(
	parameter int FRAC_BITS = ackcw_pkg::FRAC_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic                                         step,
	input  logic [ackcw_pkg::SEQ_FIELD_W-1:0]            delta,
	input  logic [ackcw_pkg::WIN_INT_W-1:0]              win_int,
	output logic [ackcw_pkg::SEQ_FIELD_W+FRAC_BITS-1:0]  quo,
	output logic                                         more
);
	import ackcw_pkg::*;

	localparam int QW    = SEQ_FIELD_W + FRAC_BITS;
	localparam int DvW   = QW + (QW % 2);
	localparam int Steps = DvW / 2;
	localparam int CntW  = $clog2(Steps + 1);

	logic [DvW-1:0]       qr_q;
	logic [WIN_INT_W-1:0] rem_q;
	logic [WIN_INT_W-1:0] dvs_q;
	logic [CntW-1:0]      cnt_q;

	logic [WIN_INT_W:0]   p1, p2;
	logic [WIN_INT_W-1:0] r1, r2;
	logic                 b1, b2;

	// two dependent compare-subtract steps
	always_comb begin
		p1 = {rem_q, qr_q[DvW-1]};
		b1 = (p1 >= {1'b0, dvs_q});
		r1 = b1 ? WIN_INT_W'(p1 - {1'b0, dvs_q}) : p1[WIN_INT_W-1:0];
		p2 = {r1, qr_q[DvW-2]};
		b2 = (p2 >= {1'b0, dvs_q});
		r2 = b2 ? WIN_INT_W'(p2 - {1'b0, dvs_q}) : p2[WIN_INT_W-1:0];
	end

	// dividend/quotient shift register and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			qr_q  <= DvW'({delta, {FRAC_BITS{1'b0}}});
			rem_q <= '0;
			dvs_q <= (win_int == '0) ? WIN_INT_W'(1) : win_int;
		end else if (step) begin
			qr_q  <= {qr_q[DvW-3:0], b1, b2};
			rem_q <= r2;
		end
	end

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(Steps);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	assign quo  = qr_q[QW-1:0];
	assign more = (cnt_q != CntW'(1));

endmodule

/* sim/ack_congestion_window_control_top_tb.sv */
// testbench of the ack congestion window controller: directed and random ack/timeout words,
// apb register access, an in-bench window predictor and a field-by-field update checker
// depends on ackcw_pkg, ackcw_evt_if, ackcw_upd_if and ack_congestion_window_control_top
module ack_congestion_window_control_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ackcw_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint unsigned WIN_CEIL = (64'd65536 << FRAC) - 1;
	localparam longint unsigned CYCLE_LIMIT = 500000;
	// settle time that covers any word still in flight
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_CHUNKS = 6;
	localparam int CHUNK_WORDS = 240;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	ackcw_evt_if ack_evt ();
	ackcw_upd_if win_upd ();

	ack_congestion_window_control_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ack_evt (ack_evt),
		.win_upd (win_upd)
	);

	// predictor copy of the registers
	longint unsigned min_win_cfg  = 64'(MIN_WINDOW_RST);
	longint unsigned ssthresh_cfg = 64'(SSTHRESH_RST);
	longint unsigned total_cfg    = 64'(TOTAL_RST);

	// predictor copy of the window state, at its reset values
	longint unsigned        cw_fixed   = 0;
	logic [SEQ_FIELD_W-1:0] acked_upto = '0;
	logic [DUP_W-1:0]       dup_acks   = '0;
	logic                   in_ss      = 1'b1;
	logic                   in_fr      = 1'b0;
	logic [SEQ_FIELD_W-1:0] snd_base   = '0;
	logic [SEQ_FIELD_W-1:0] snd_tail   = '0;
	logic                   xfer_done  = 1'b0;

	upd_word_t       expected_updates[$];
	int              fail_count = 0;
	bit              no_gaps = 1'b0;
	longint unsigned cycle_count = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** ack_congestion_window_control_top: FAILED **");
		$finish;
	end

	function automatic longint unsigned sat_window(input longint unsigned w);
		return (w > WIN_CEIL) ? WIN_CEIL : w;
	endfunction

	function automatic void count_dup();
		if (dup_acks != {DUP_W{1'b1}})
			dup_acks = dup_acks + DUP_W'(1);
	endfunction

	function automatic void tail_from_window();
		snd_tail = snd_base + SEQ_FIELD_W'(cw_fixed >> FRAC) - SEQ_FIELD_W'(1);
	endfunction

	// next window update for one ack or timeout word; advances the predicted state
	function automatic upd_word_t predict_update(input logic req,
			input logic [SEQ_FIELD_W-1:0] ack);
		longint unsigned delta;
		longint unsigned grown;
		longint unsigned divisor;
		upd_word_t res;
		res = '0;
		if (!xfer_done) begin
			if (req) begin
				// timeout: back to slow start at the minimum window
				cw_fixed = sat_window(min_win_cfg << FRAC);
				dup_acks = '0;
				in_ss = 1'b1;
				in_fr = 1'b0;
				snd_tail = snd_base;
			end else if (ack == SEQ_FIELD_W'(total_cfg)) begin
				xfer_done = 1'b1;
			end else begin
				// slow start, or congestion avoidance once past the threshold
				if (in_ss) begin
					if (acked_upto < ack) begin
						delta = 64'(ack - acked_upto);
						grown = cw_fixed + (delta << (FRAC + 1));
						if (grown > (ssthresh_cfg << FRAC)) begin
							divisor = cw_fixed >> FRAC;
							if (divisor == 0)
								divisor = 1;
							cw_fixed = sat_window(cw_fixed + (delta << FRAC) / divisor);
						end else begin
							cw_fixed = sat_window(grown);
						end
						dup_acks = '0;
						snd_base = snd_base + SEQ_FIELD_W'(delta);
						tail_from_window();
						acked_upto = ack;
					end else if (acked_upto == ack) begin
						count_dup();
					end
				end
				// fast recovery: inflate on duplicates, deflate on a new ack
				if (in_fr) begin
					if (acked_upto == ack) begin
						cw_fixed = sat_window(cw_fixed + (64'd1 << FRAC));
						count_dup();
						res.retransmit_valid = 1'b1;
						res.retransmit_seq = ack + SEQ_FIELD_W'(1);
						snd_tail = snd_tail + SEQ_FIELD_W'(1);
					end else if (acked_upto < ack) begin
						delta = 64'(ack - acked_upto);
						cw_fixed = sat_window(ssthresh_cfg << FRAC);
						dup_acks = '0;
						snd_base = snd_base + SEQ_FIELD_W'(delta);
						tail_from_window();
						acked_upto = ack;
						in_ss = 1'b1;
						in_fr = 1'b0;
					end
				end
				// third duplicate enters fast recovery
				if (dup_acks == DUP_ENTER) begin
					in_fr = 1'b1;
					in_ss = 1'b0;
					cw_fixed = sat_window(min_win_cfg << FRAC);
					tail_from_window();
					res.retransmit_valid = 1'b1;
					res.retransmit_seq = ack + SEQ_FIELD_W'(1);
				end
			end
		end
		res.window_base = snd_base;
		res.window_tail = snd_tail;
		res.congestion_window = WIN_INT_W'(cw_fixed >> FRAC);
		res.transfer_done = xfer_done;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// update sink: compares each word with the oldest prediction, then stalls at random
	initial begin : update_checker
		upd_word_t got;
		upd_word_t want;
		int unsigned stall;
		forever begin
			@(posedge clk);
			if (win_upd.valid === 1'b1 && win_upd.ready === 1'b1) begin
				got = win_upd.item;
				if (expected_updates.size() == 0) begin
					$error("window update word with nothing expected");
					fail_count++;
				end else begin
					want = expected_updates.pop_front();
					check_field("window_base", 32'(want.window_base), 32'(got.window_base));
					check_field("window_tail", 32'(want.window_tail), 32'(got.window_tail));
					check_field("congestion_window", 32'(want.congestion_window),
						32'(got.congestion_window));
					check_field("retransmit_valid", 32'(want.retransmit_valid),
						32'(got.retransmit_valid));
					check_field("retransmit_seq", 32'(want.retransmit_seq),
						32'(got.retransmit_seq));
					check_field("transfer_done", 32'(want.transfer_done),
						32'(got.transfer_done));
				end
				stall = no_gaps ? 0 : $urandom_range(0, 15);
				if (stall != 0) begin
					win_upd.ready <= 1'b0;
					repeat (stall) @(posedge clk);
					win_upd.ready <= 1'b1;
				end
			end
		end
	end

	// drive one event word after a random gap and wait until it is taken
	task automatic send_event(input logic req, input logic [SEQ_FIELD_W-1:0] ack);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			ack_evt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ack_evt.valid <= 1'b1;
		ack_evt.item <= '{req_type: req, ack_number: ack};
		expected_updates.push_back(predict_update(req, ack));
		do @(posedge clk); while (ack_evt.ready !== 1'b1);
	endtask

	// ack word that stays clear of the end of the transfer
	task automatic send_ack(input logic [SEQ_FIELD_W-1:0] ack);
		if (ack == SEQ_FIELD_W'(total_cfg))
			ack = ack + SEQ_FIELD_W'(1);
		send_event(1'b0, ack);
	endtask

	// hold the sender until every predicted update has come back
	task automatic drain_updates();
		ack_evt.valid <= 1'b0;
		do @(posedge clk); while (expected_updates.size() != 0);
	endtask

	task automatic apb_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MIN_WINDOW: min_win_cfg = 64'(val[WIN_INT_W-1:0]);
			REG_SSTHRESH: ssthresh_cfg = 64'(val[WIN_INT_W-1:0]);
			REG_TOTAL: total_cfg = 64'(val[SEQ_FIELD_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apb_read_check(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CFG_ADDR_W'(idx) << 2;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		check_field(idx.name(), want, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only with the block idle
	task automatic set_config(input logic [WIN_INT_W-1:0] min_win,
			input logic [WIN_INT_W-1:0] ssthresh, input logic [SEQ_FIELD_W-1:0] total);
		drain_updates();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_write(REG_MIN_WINDOW, CFG_DATA_W'(min_win));
		apb_write(REG_SSTHRESH, CFG_DATA_W'(ssthresh));
		apb_write(REG_TOTAL, CFG_DATA_W'(total));
		apb_read_check(REG_MIN_WINDOW, CFG_DATA_W'(min_win));
		apb_read_check(REG_SSTHRESH, CFG_DATA_W'(ssthresh));
		apb_read_check(REG_TOTAL, CFG_DATA_W'(total));
	endtask

	function automatic int unsigned pick_delta();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		else if (r < 95)
			return $urandom_range(9, 600);
		return $urandom_range(601, 20000);
	endfunction

	task automatic test_register_access();
		apb_read_check(REG_MIN_WINDOW, CFG_DATA_W'(MIN_WINDOW_RST));
		apb_read_check(REG_SSTHRESH, CFG_DATA_W'(SSTHRESH_RST));
		apb_read_check(REG_TOTAL, CFG_DATA_W'(TOTAL_RST));
		set_config(16'd4, 16'd16, 24'hFFFFFF);
	endtask

	// first ack divides by a zero window, then old ack, avoidance, timeout, slow start
	task automatic test_slow_start_growth();
		send_event(1'b0, 24'd40);
		send_event(1'b0, 24'd0);
		send_event(1'b0, 24'd41);
		send_event(1'b1, 24'hFFFFFF);
		send_event(1'b0, 24'd43);
		send_event(1'b0, 24'd45);
	endtask

	// third duplicate enters, fourth inflates, old ack ignored, new ack exits
	task automatic test_fast_recovery();
		repeat (4) send_event(1'b0, 24'd45);
		send_event(1'b0, 24'd44);
		send_event(1'b0, 24'd60);
	endtask

	// largest window and threshold; inflation saturates the window
	task automatic test_window_saturation();
		set_config(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		send_event(1'b1, 24'd0);
		repeat (4) send_event(1'b0, 24'd60);
		send_event(1'b0, 24'd70);
	endtask

	// smallest window and threshold; a huge ack saturates through avoidance
	task automatic test_small_window();
		set_config(16'd1, 16'd1, 24'h123456);
		send_event(1'b1, 24'h5A5A5A);
		send_event(1'b0, 24'd71);
		send_event(1'b0, 24'd71 + 24'h800000);
	endtask

	// random settings, then mostly well-formed ack runs with random content
	task automatic test_random_traffic(input int words, input bit quiet);
		logic [WIN_INT_W-1:0] min_win;
		logic [WIN_INT_W-1:0] ssthresh;
		int sent;
		int unsigned pick;
		int unsigned run;
		logic req;
		case ($urandom_range(0, 3))
			0: min_win = 16'd1;
			1: min_win = 16'hFFFF;
			default: min_win = WIN_INT_W'($urandom_range(2, 64));
		endcase
		case ($urandom_range(0, 3))
			0: ssthresh = 16'd1;
			1: ssthresh = 16'hFFFF;
			default: ssthresh = WIN_INT_W'($urandom_range(4, 1024));
		endcase
		set_config(min_win, ssthresh, SEQ_FIELD_W'($urandom_range(0, 24'hFFFFFF)));
		no_gaps = quiet;
		sent = 0;
		while (sent < words) begin
			pick = $urandom_range(0, 19);
			if (pick < 8) begin
				// run of new acks
				run = $urandom_range(1, 4);
				repeat (run) begin
					send_ack(acked_upto + SEQ_FIELD_W'(pick_delta()));
					sent++;
				end
			end else if (pick < 14) begin
				// duplicates short of, up to and past fast recovery entry, then a new ack
				run = $urandom_range(2, 6);
				repeat (run) begin
					send_ack(acked_upto);
					sent++;
				end
				send_ack(acked_upto + SEQ_FIELD_W'(pick_delta()));
				sent++;
			end else if (pick < 16) begin
				// stale ack
				send_ack((acked_upto == '0) ? '0 :
					SEQ_FIELD_W'($urandom_range(0, 32'(acked_upto - SEQ_FIELD_W'(1)))));
				sent++;
			end else if (pick < 18) begin
				send_event(1'b1, SEQ_FIELD_W'($urandom_range(0, 24'hFFFFFF)));
				sent++;
			end else begin
				// noise around the last ack
				req = 1'($urandom_range(0, 1));
				if (req)
					send_event(1'b1, acked_upto ^ SEQ_FIELD_W'($urandom_range(0, 255)));
				else
					send_ack(acked_upto ^ SEQ_FIELD_W'($urandom_range(0, 255)));
				sent++;
			end
			if ($urandom_range(0, 39) == 0)
				drain_updates();
		end
		no_gaps = 1'b0;
	endtask

	// top ack: tail and retransmit sequence wrap around
	task automatic test_sequence_wrap();
		set_config(16'd8, 16'd64, 24'd0);
		send_event(1'b0, 24'hFFFFFF);
		repeat (4) send_event(1'b0, 24'hFFFFFF);
		send_event(1'b1, 24'd0);
	endtask

	// ack equal to the total ends the transfer; later words change nothing
	task automatic test_transfer_done();
		send_event(1'b0, 24'd0);
		send_event(1'b0, 24'hFFFFFF);
		send_event(1'b1, 24'h0F0F0F);
		send_event(1'b0, 24'd0);
	endtask

	initial begin : run_tests
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		ack_evt.valid <= 1'b0;
		ack_evt.item <= '0;
		win_upd.ready <= 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_slow_start_growth();
		test_fast_recovery();
		test_window_saturation();
		test_small_window();
		for (int i = 0; i < RANDOM_CHUNKS; i++)
			test_random_traffic(CHUNK_WORDS, (i % 3) == 2);
		test_sequence_wrap();
		test_transfer_done();

		drain_updates();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** ack_congestion_window_control_top: PASSED **");
		else
			$display("** ack_congestion_window_control_top: FAILED **");
		$finish;
	end
endmodule
